FILE: rtl/core/tli_pkg.sv
`default_nettype none
package tli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int QUO_W      = DATA_W + 1;
  localparam int DCNT_W     = $clog2(QUO_W + 1);
  localparam int IDX_W      = 6;
  localparam int PIN_W      = 7;
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [APB_AW-1:0] REG_POINTS_IN_USE = '0;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             big;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ENDS,
    ST_PROBE,
    ST_CMP,
    ST_DIFF,
    ST_DIV,
    ST_RES
  } st_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHK,
    DV_LOOP
  } dv_st_t;

endpackage
`default_nettype wire

FILE: rtl/core/tli_if.sv
`default_nettype none
interface tli_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [tli_pkg::IDX_W-1:0]        entry_index;
  logic signed [tli_pkg::DATA_W-1:0] entry_x;
  logic signed [tli_pkg::DATA_W-1:0] entry_y;
  logic signed [tli_pkg::DATA_W-1:0] query_x;

  modport source (output valid, func, entry_index, entry_x, entry_y, query_x, input ready);
  modport sink (input valid, func, entry_index, entry_x, entry_y, query_x, output ready);
endinterface

interface tli_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tli_pkg::DATA_W-1:0] out_y;
  logic                             out_valid;

  modport source (output valid, out_y, out_valid, input ready);
  modport sink (input valid, out_y, out_valid, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tli_table.sv
`default_nettype none
module tli_table (
  input  wire                          clk,
  input  tli_pkg::tbl_wr_t             wr,
  input  wire [tli_pkg::PTR_W-1:0]     rd_addr_a,
  input  wire [tli_pkg::PTR_W-1:0]     rd_addr_b,
  output tli_pkg::entry_t              rd_data_a,
  output tli_pkg::entry_t              rd_data_b
);

  tli_pkg::entry_t mem [tli_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

FILE: rtl/core/tli_muldiv.sv
`default_nettype none
module tli_muldiv (
  input  wire               clk,
  input  wire               rst,
  input  tli_pkg::div_req_t req,
  output tli_pkg::div_rsp_t rsp
);

  tli_pkg::dv_st_t dstate, dstate_next;

  logic [tli_pkg::DATA_W-1:0] a, a_next;
  logic [tli_pkg::DATA_W-1:0] b, b_next;
  logic [tli_pkg::DATA_W-1:0] d, d_next;
  logic [tli_pkg::PROD_W-1:0] prod, prod_next;
  logic [tli_pkg::DATA_W-1:0] rem, rem_next;
  logic [tli_pkg::QUO_W-1:0]  num, num_next;
  logic [tli_pkg::DCNT_W-1:0] cnt, cnt_next;
  logic                       done, done_next;
  logic                       big, big_next;
  logic [tli_pkg::DATA_W:0]   trial;
  logic [tli_pkg::DATA_W:0]   diff;

  assign rsp.done = done;
  assign rsp.big  = big;
  assign rsp.quo  = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= tli_pkg::DV_IDLE;
      done   <= 1'b0;
    end else begin
      dstate <= dstate_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    a    <= a_next;
    b    <= b_next;
    d    <= d_next;
    prod <= prod_next;
    rem  <= rem_next;
    num  <= num_next;
    cnt  <= cnt_next;
    big  <= big_next;
  end

  always_comb begin
    dstate_next = dstate;
    a_next      = a;
    b_next      = b;
    d_next      = d;
    prod_next   = prod;
    rem_next    = rem;
    num_next    = num;
    cnt_next    = cnt;
    big_next    = big;
    done_next   = 1'b0;
    // one restoring step: next dividend bit into the remainder
    trial       = {rem, num[tli_pkg::QUO_W-1]};
    diff        = trial - {1'b0, d};
    case (dstate)
      tli_pkg::DV_IDLE: begin
        if (req.start) begin
          a_next      = req.a;
          b_next      = req.b;
          d_next      = req.d;
          dstate_next = tli_pkg::DV_MUL;
        end
      end
      tli_pkg::DV_MUL: begin
        prod_next   = a * b;
        dstate_next = tli_pkg::DV_CHK;
      end
      tli_pkg::DV_CHK: begin
        // quotient needs more than QUO_W bits: caller saturates
        if ({1'b0, prod[tli_pkg::PROD_W-1:tli_pkg::QUO_W]} >= d) begin
          big_next    = 1'b1;
          done_next   = 1'b1;
          dstate_next = tli_pkg::DV_IDLE;
        end else begin
          big_next    = 1'b0;
          rem_next    = {1'b0, prod[tli_pkg::PROD_W-1:tli_pkg::QUO_W]};
          num_next    = prod[tli_pkg::QUO_W-1:0];
          cnt_next    = tli_pkg::DCNT_W'(tli_pkg::QUO_W);
          dstate_next = tli_pkg::DV_LOOP;
        end
      end
      tli_pkg::DV_LOOP: begin
        if (trial >= {1'b0, d}) begin
          rem_next = diff[tli_pkg::DATA_W-1:0];
          num_next = {num[tli_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_next = trial[tli_pkg::DATA_W-1:0];
          num_next = {num[tli_pkg::QUO_W-2:0], 1'b0};
        end
        cnt_next = cnt - 1'b1;
        if (cnt == tli_pkg::DCNT_W'(1)) begin
          done_next   = 1'b1;
          dstate_next = tli_pkg::DV_IDLE;
        end
      end
      default: begin
        dstate_next = tli_pkg::DV_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/table_linear_interpolator.sv
`default_nettype none
// Breakpoint table lookup with linear interpolation in signed Q16.16. An input item with
// func 0 writes one (x, y) breakpoint and gives no result; ready stays high. An item
// with func 1 gives one result item: with fewer than two points in use it repeats the
// last valid y with out_valid 0, outside the table it clamps to the end y, otherwise it
// binary searches the table (each probe reads two entries of a two-read-port table, at
// most six probes with 64 points) and interpolates through a shared multiply and a
// 33-step restoring divider. A lookup holds ready low until its result is placed in the
// output register. A finished result waits in that register, so the next item is taken
// while it is not yet collected; a lookup that finishes while the previous result still
// waits holds ready low until that one is taken. The table is assumed strictly ascending
// in x; entries that a lookup reads must have been written. points_in_use is written
// over the APB port at address 0. The user must write it only while the block is idle;
// the block itself does not enforce this.
module table_linear_interpolator (
  input  wire                          clk,
  input  wire                          rst,
  tli_in_if.sink                       in_ch,
  tli_out_if.source                    out_ch,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [tli_pkg::APB_AW-1:0]    paddr,
  input  wire [tli_pkg::APB_DW-1:0]    pwdata,
  output logic [tli_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int SUM_W = tli_pkg::DATA_W + 3;
  localparam logic signed [tli_pkg::DATA_W-1:0] Y_MAX = {1'b0, {(tli_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [tli_pkg::DATA_W-1:0] Y_MIN = {1'b1, {(tli_pkg::DATA_W-1){1'b0}}};

  tli_pkg::st_t state, state_next;

  logic [tli_pkg::PIN_W-1:0]         pin;
  logic [tli_pkg::CNT_W-1:0]         n;
  logic signed [tli_pkg::DATA_W-1:0] qx, qx_next;
  logic signed [tli_pkg::DATA_W-1:0] xs, xs_next;
  logic signed [tli_pkg::DATA_W-1:0] ys, ys_next;
  logic signed [tli_pkg::DATA_W-1:0] xe, xe_next;
  logic signed [tli_pkg::DATA_W-1:0] ye, ye_next;
  logic [tli_pkg::PTR_W-1:0]         l, l_next;
  logic [tli_pkg::PTR_W-1:0]         r, r_next;
  logic [tli_pkg::PTR_W-1:0]         m, m_next;
  logic [tli_pkg::PTR_W-1:0]         mid;
  logic                              neg, neg_next;
  logic signed [tli_pkg::DATA_W-1:0] res, res_next;
  logic                              res_ok, res_ok_next;
  logic signed [tli_pkg::DATA_W-1:0] last_y, last_y_next;
  logic                              ovalid, ovalid_next;
  logic signed [tli_pkg::DATA_W-1:0] oy, oy_next;
  logic                              ook, ook_next;
  logic                              in_ready;
  logic [SUM_W-1:0]                  ye_ext;
  logic [SUM_W-1:0]                  q_ext;
  logic [SUM_W-1:0]                  sum;

  tli_pkg::tbl_wr_t          tbl_wr;
  logic [tli_pkg::PTR_W-1:0] rd_addr_a;
  logic [tli_pkg::PTR_W-1:0] rd_addr_b;
  tli_pkg::entry_t           ea;
  tli_pkg::entry_t           eb;
  tli_pkg::div_req_t         div_req;
  tli_pkg::div_rsp_t         div_rsp;

  tli_table u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ea),
    .rd_data_b (eb)
  );

  tli_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == tli_pkg::REG_POINTS_IN_USE) ?
                  tli_pkg::APB_DW'(pin) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == tli_pkg::REG_POINTS_IN_USE) begin
      pin <= pwdata[tli_pkg::PIN_W-1:0];
    end
  end

  always_comb begin
    if (32'(pin) > 32'(tli_pkg::MAX_POINTS)) begin
      n = tli_pkg::CNT_W'(tli_pkg::MAX_POINTS);
    end else begin
      n = tli_pkg::CNT_W'(pin);
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = ovalid;
  assign out_ch.out_y     = oy;
  assign out_ch.out_valid = ook;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tli_pkg::ST_IDLE;
      ovalid <= 1'b0;
      last_y <= '0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
      last_y <= last_y_next;
    end
  end

  always_ff @(posedge clk) begin
    qx     <= qx_next;
    xs     <= xs_next;
    ys     <= ys_next;
    xe     <= xe_next;
    ye     <= ye_next;
    l      <= l_next;
    r      <= r_next;
    m      <= m_next;
    neg    <= neg_next;
    res    <= res_next;
    res_ok <= res_ok_next;
    oy     <= oy_next;
    ook    <= ook_next;
  end

  always_comb begin
    state_next  = state;
    qx_next     = qx;
    xs_next     = xs;
    ys_next     = ys;
    xe_next     = xe;
    ye_next     = ye;
    l_next      = l;
    r_next      = r;
    m_next      = m;
    neg_next    = neg;
    res_next    = res;
    res_ok_next = res_ok;
    last_y_next = last_y;
    oy_next     = oy;
    ook_next    = ook;
    ovalid_next = ovalid && !out_ch.ready;
    in_ready    = 1'b0;
    tbl_wr      = '0;
    rd_addr_a   = '0;
    rd_addr_b   = '0;
    div_req     = '0;
    mid         = l + ((r - l) >> 1);
    ye_ext      = {{(SUM_W-tli_pkg::DATA_W){ye[tli_pkg::DATA_W-1]}}, ye};
    q_ext       = {{(SUM_W-tli_pkg::QUO_W){1'b0}}, div_rsp.quo};
    sum         = neg ? (ye_ext + q_ext) : (ye_ext - q_ext);
    case (state)
      tli_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.func == tli_pkg::FUNC_LOOKUP) begin
            qx_next    = in_ch.query_x;
            state_next = tli_pkg::ST_START;
          end else if (32'(in_ch.entry_index) < 32'(tli_pkg::MAX_POINTS)) begin
            tbl_wr.en     = 1'b1;
            tbl_wr.addr   = tli_pkg::PTR_W'(in_ch.entry_index);
            tbl_wr.data.x = in_ch.entry_x;
            tbl_wr.data.y = in_ch.entry_y;
          end
        end
      end
      tli_pkg::ST_START: begin
        if (n < tli_pkg::CNT_W'(2)) begin
          res_next    = last_y;
          res_ok_next = 1'b0;
          state_next  = tli_pkg::ST_RES;
        end else begin
          rd_addr_a  = '0;
          rd_addr_b  = tli_pkg::PTR_W'(n - 1'b1);
          state_next = tli_pkg::ST_ENDS;
        end
      end
      tli_pkg::ST_ENDS: begin
        res_ok_next = 1'b1;
        if (qx >= eb.x) begin
          res_next   = eb.y;
          state_next = tli_pkg::ST_RES;
        end else if (qx <= ea.x) begin
          res_next   = ea.y;
          state_next = tli_pkg::ST_RES;
        end else begin
          // first and last points stand in if no bracket is found
          xs_next    = ea.x;
          ys_next    = ea.y;
          xe_next    = eb.x;
          ye_next    = eb.y;
          l_next     = '0;
          r_next     = tli_pkg::PTR_W'(n - 1'b1);
          state_next = tli_pkg::ST_PROBE;
        end
      end
      tli_pkg::ST_PROBE: begin
        if (l < r) begin
          m_next     = mid;
          rd_addr_a  = mid;
          rd_addr_b  = mid + 1'b1;
          state_next = tli_pkg::ST_CMP;
        end else begin
          state_next = tli_pkg::ST_DIFF;
        end
      end
      tli_pkg::ST_CMP: begin
        if (qx > eb.x) begin
          l_next     = m + 1'b1;
          state_next = tli_pkg::ST_PROBE;
        end else if (qx < ea.x) begin
          r_next     = m;
          state_next = tli_pkg::ST_PROBE;
        end else begin
          xs_next    = ea.x;
          ys_next    = ea.y;
          xe_next    = eb.x;
          ye_next    = eb.y;
          state_next = tli_pkg::ST_DIFF;
        end
      end
      tli_pkg::ST_DIFF: begin
        if (xe == xs) begin
          res_next   = ye;
          state_next = tli_pkg::ST_RES;
        end else begin
          // magnitudes of the differences fit in 32 bits unsigned
          div_req.start = 1'b1;
          div_req.a     = (xe >= qx) ? ($unsigned(xe) - $unsigned(qx))
                                     : ($unsigned(qx) - $unsigned(xe));
          div_req.b     = (ye >= ys) ? ($unsigned(ye) - $unsigned(ys))
                                     : ($unsigned(ys) - $unsigned(ye));
          div_req.d     = (xe >= xs) ? ($unsigned(xe) - $unsigned(xs))
                                     : ($unsigned(xs) - $unsigned(xe));
          neg_next      = (xe < qx) ^ (ye < ys) ^ (xe < xs);
          state_next    = tli_pkg::ST_DIV;
        end
      end
      tli_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.big) begin
            res_next = neg ? Y_MAX : Y_MIN;
          end else if (sum[SUM_W-1:tli_pkg::DATA_W-1] == '0 ||
                       sum[SUM_W-1:tli_pkg::DATA_W-1] == '1) begin
            res_next = sum[tli_pkg::DATA_W-1:0];
          end else begin
            res_next = sum[SUM_W-1] ? Y_MIN : Y_MAX;
          end
          state_next = tli_pkg::ST_RES;
        end
      end
      tli_pkg::ST_RES: begin
        if (!ovalid || out_ch.ready) begin
          ovalid_next = 1'b1;
          oy_next     = res;
          ook_next    = res_ok;
          if (res_ok) begin
            last_y_next = res;
          end
          state_next = tli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/tli_checker.sv
`default_nettype none
module tli_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          in_func,
  input wire                          out_v,
  input wire                          out_rdy,
  input wire [tli_pkg::DATA_W-1:0]    out_y,
  input wire                          out_ok
);

  // a lookup item keeps the input side closed on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_func == tli_pkg::FUNC_LOOKUP) |=> !in_ready)
    else $error("input ready right after a lookup item");

  // a table write item leaves the input side open
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_func == tli_pkg::FUNC_WRITE) |=> in_ready)
    else $error("input ready dropped after a write item");

  assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_rdy) |=> out_v)
    else $error("result item withdrawn while stalled");

  assert property (@(posedge clk) disable iff (rst)
    (out_v && !out_rdy) |=> ($stable(out_y) && $stable(out_ok)))
    else $error("result item changed while stalled");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_func  (in_ch.func),
  .out_v    (out_ch.valid),
  .out_rdy  (out_ch.ready),
  .out_y    (out_ch.out_y),
  .out_ok   (out_ch.out_valid)
);
`default_nettype wire

FILE: test/table_linear_interpolator_tb.sv
`default_nettype none
module table_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int ITEM_TARGET  = 1100;
  localparam int HOLD_CYCLES  = 500;
  localparam int SETTLE_WAIT  = 64;
  localparam logic signed [tli_pkg::DATA_W-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [tli_pkg::DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
  localparam longint Q_MIN_L = -64'sd2147483648;
  localparam longint Q_MAX_L = 64'sd2147483647;

  typedef struct {
    logic                              func;
    logic [tli_pkg::IDX_W-1:0]         idx;
    logic signed [tli_pkg::DATA_W-1:0] ex;
    logic signed [tli_pkg::DATA_W-1:0] ey;
    logic signed [tli_pkg::DATA_W-1:0] qx;
  } tbl_item_t;

  typedef struct {
    logic signed [tli_pkg::DATA_W-1:0] y;
    logic                              ok;
  } lookup_res_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tli_pkg::APB_AW-1:0] paddr;
  logic [tli_pkg::APB_DW-1:0] pwdata;
  logic [tli_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  tli_in_if  in_ch ();
  tli_out_if out_ch ();

  table_linear_interpolator u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // stimulus side
  tbl_item_t                         pending_items[$];
  tbl_item_t                         feed_item;
  logic signed [tli_pkg::DATA_W-1:0] sx[tli_pkg::MAX_POINTS];
  logic signed [tli_pkg::DATA_W-1:0] sy[tli_pkg::MAX_POINTS];
  int  n_pushed   = 0;
  int  n_offered  = 0;
  int  n_accepted = 0;
  int  gap_left   = 0;
  bit  idle_mode  = 1'b1;
  int  hold_asked = 0;
  int  hold_done  = 0;
  int  hold_left  = 0;
  int  stall_left = 0;
  int  rx_seen    = 0;
  int  cycles     = 0;

  // interpolation predictor state
  logic signed [tli_pkg::DATA_W-1:0] tbl_x[tli_pkg::MAX_POINTS];
  logic signed [tli_pkg::DATA_W-1:0] tbl_y[tli_pkg::MAX_POINTS];
  logic signed [tli_pkg::DATA_W-1:0] held_y = '0;
  logic [tli_pkg::PIN_W-1:0]         points_cfg = '0;
  lookup_res_t                       expected_res[$];
  lookup_res_t                       want;

  int n_writes   = 0;
  int n_lookups  = 0;
  int n_interp   = 0;
  int n_clamp    = 0;
  int n_unusable = 0;
  int n_results  = 0;
  int n_errors   = 0;

  function automatic void interpolate_item(logic f, logic [tli_pkg::IDX_W-1:0] idx,
                                           logic signed [tli_pkg::DATA_W-1:0] ex,
                                           logic signed [tli_pkg::DATA_W-1:0] ey,
                                           logic signed [tli_pkg::DATA_W-1:0] qx);
    lookup_res_t                       r;
    int                                n;
    int                                lo;
    int                                hi;
    int                                mid;
    bit                                found;
    logic signed [tli_pkg::DATA_W-1:0] xs;
    logic signed [tli_pkg::DATA_W-1:0] xe;
    logic signed [tli_pkg::DATA_W-1:0] ys;
    logic signed [tli_pkg::DATA_W-1:0] ye;
    logic signed [33:0]                dx;
    logic signed [33:0]                dy;
    logic signed [33:0]                span;
    logic [33:0]                       mdx;
    logic [33:0]                       mdy;
    logic [33:0]                       mspan;
    logic [67:0]                       quo;
    logic signed [71:0]                yw;
    logic signed [71:0]                qw;
    logic signed [71:0]                res;
    logic                              neg;
    if (f == tli_pkg::FUNC_WRITE) begin
      tbl_x[idx] = ex;
      tbl_y[idx] = ey;
      n_writes++;
      return;
    end
    n_lookups++;
    n = (points_cfg > tli_pkg::MAX_POINTS) ? tli_pkg::MAX_POINTS : int'(points_cfg);
    if (n < 2) begin
      r.y  = held_y;
      r.ok = 1'b0;
      n_unusable++;
      expected_res.push_back(r);
      return;
    end
    if (qx >= tbl_x[n-1]) begin
      res = tbl_y[n-1];
      n_clamp++;
    end else if (qx <= tbl_x[0]) begin
      res = tbl_y[0];
      n_clamp++;
    end else begin
      xs = tbl_x[0];
      ys = tbl_y[0];
      xe = tbl_x[n-1];
      ye = tbl_y[n-1];
      lo = 0;
      hi = n - 1;
      found = 1'b0;
      while (lo < hi && !found) begin
        mid = lo + (hi - lo) / 2;
        if (qx > tbl_x[mid+1]) begin
          lo = mid + 1;
        end else if (qx < tbl_x[mid]) begin
          hi = mid;
        end else begin
          xs = tbl_x[mid];
          ys = tbl_y[mid];
          xe = tbl_x[mid+1];
          ye = tbl_y[mid+1];
          found = 1'b1;
        end
      end
      yw = ye;
      if (xe == xs) begin
        res = yw;
      end else begin
        dx    = xe - qx;
        dy    = ye - ys;
        span  = xe - xs;
        neg   = (dx < 0) ^ (dy < 0) ^ (span < 0);
        mdx   = (dx < 0) ? -dx : dx;
        mdy   = (dy < 0) ? -dy : dy;
        mspan = (span < 0) ? -span : span;
        // full-width product, quotient truncated toward zero
        quo = (68'(mdx) * 68'(mdy)) / 68'(mspan);
        qw  = $signed({4'b0, quo});
        res = neg ? yw + qw : yw - qw;
      end
      if (res > Q_MAX_L) res = Q_MAX_L;
      if (res < Q_MIN_L) res = Q_MIN_L;
      n_interp++;
    end
    r.y    = res[tli_pkg::DATA_W-1:0];
    r.ok   = 1'b1;
    held_y = r.y;
    expected_res.push_back(r);
  endfunction

  function automatic logic signed [tli_pkg::DATA_W-1:0] rand_between(longint lo,
                                                                      longint hi);
    logic [63:0] r;
    longint      w;
    w = hi - lo + 1;
    r = {$urandom, $urandom};
    return tli_pkg::DATA_W'(lo + longint'(r % 64'(w)));
  endfunction

  function automatic void add_write(int idx, logic signed [tli_pkg::DATA_W-1:0] x,
                                    logic signed [tli_pkg::DATA_W-1:0] y);
    tbl_item_t it;
    it.func = tli_pkg::FUNC_WRITE;
    it.idx  = tli_pkg::IDX_W'(idx);
    it.ex   = x;
    it.ey   = y;
    it.qx   = $urandom;
    sx[idx] = x;
    sy[idx] = y;
    pending_items.push_back(it);
    n_pushed++;
  endfunction

  function automatic void add_lookup(logic signed [tli_pkg::DATA_W-1:0] q);
    tbl_item_t it;
    it.func = tli_pkg::FUNC_LOOKUP;
    it.idx  = tli_pkg::IDX_W'($urandom);
    it.ex   = $urandom;
    it.ey   = $urandom;
    it.qx   = q;
    pending_items.push_back(it);
    n_pushed++;
  endfunction

  function automatic logic signed [tli_pkg::DATA_W-1:0] pick_query(int n);
    int                                m;
    logic signed [tli_pkg::DATA_W-1:0] a;
    logic signed [tli_pkg::DATA_W-1:0] b;
    m = (n < 2) ? 2 : n;
    a = (sx[0] < sx[m-1]) ? sx[0] : sx[m-1];
    b = (sx[0] < sx[m-1]) ? sx[m-1] : sx[0];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? a : b;
      2: return sx[$urandom_range(0, m - 1)];
      3: return sx[$urandom_range(0, m - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      default: return rand_between(a, b);
    endcase
  endfunction

  // style: 0 ascending, 1 ascending over the whole range, 2 narrow with repeats,
  // 3 unordered
  function automatic void load_table(int n, int style);
    longint                            cur;
    longint                            budget;
    logic signed [tli_pkg::DATA_W-1:0] x;
    logic signed [tli_pkg::DATA_W-1:0] y;
    cur = (style == 1) ? Q_MIN_L :
          (style == 2) ? longint'(rand_between(-3000, 3000)) :
                         longint'(rand_between(Q_MIN_L, 0));
    for (int i = 0; i < n; i++) begin
      if (style == 3) begin
        x = $urandom;
      end else begin
        x = tli_pkg::DATA_W'(cur);
        if (i < n - 1) begin
          budget = (Q_MAX_L - cur) / (n - 1 - i);
          // a step must fit the 32-bit draw
          if (budget > Q_MAX_L) budget = Q_MAX_L;
          cur += (style == 2) ? longint'($urandom_range(0, 3)) :
                                longint'(rand_between(1, budget));
        end
        if (style == 1 && i == n - 1) x = Q_MAX;
      end
      if (style == 1) y = (i % 2) ? Q_MAX : Q_MIN;
      else if ($urandom_range(0, 3) == 0) y = rand_between(-(64'sd1 << 20), 64'sd1 << 20);
      else y = $urandom;
      add_write(i, x, y);
    end
  endfunction

  // wait until every item is taken and every result is back
  task automatic settle();
    while (pending_items.size() != 0 || n_accepted != n_pushed || expected_res.size() != 0)
      @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_points(int n);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tli_pkg::REG_POINTS_IN_USE;
    pwdata  <= tli_pkg::APB_DW'(n);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    points_cfg = tli_pkg::PIN_W'(n);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== tli_pkg::APB_DW'(n)) begin
      $display("%0t: points_in_use readback: expected %0d, got %0d", $time, n, prdata);
      n_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || n_accepted == n_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        feed_item = pending_items.pop_front();
        in_ch.func        <= feed_item.func;
        in_ch.entry_index <= feed_item.idx;
        in_ch.entry_x     <= feed_item.ex;
        in_ch.entry_y     <= feed_item.ey;
        in_ch.query_x     <= feed_item.qx;
        in_ch.valid       <= 1'b1;
        n_offered++;
        gap_left = idle_mode ? $urandom_range(0, 10) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      interpolate_item(in_ch.func, in_ch.entry_index, in_ch.entry_x, in_ch.entry_y,
                       in_ch.query_x);
      n_accepted++;
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_seen != n_results) begin
        rx_seen    = n_results;
        stall_left = idle_mode ? $urandom_range(0, 10) : 0;
      end
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_res.size() == 0) begin
        $display("%0t: result item with none due: out_y %h out_valid %b", $time,
                 out_ch.out_y, out_ch.out_valid);
        n_errors++;
      end else begin
        want = expected_res.pop_front();
        if (out_ch.out_y !== want.y) begin
          $display("%0t: out_y mismatch: expected %h, got %h", $time, want.y, out_ch.out_y);
          n_errors++;
        end
        if (out_ch.out_valid !== want.ok) begin
          $display("%0t: out_valid mismatch: expected %b, got %b", $time, want.ok,
                   out_ch.out_valid);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results still due", $time, expected_res.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int n;
    int style;
    int count;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.func        = tli_pkg::FUNC_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_x     = '0;
    in_ch.entry_y     = '0;
    in_ch.query_x     = '0;
    out_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table, then a four point table with a repeated x
    set_points(0);
    add_lookup(0);
    add_write(0, Q_MIN, Q_MAX);
    add_write(1, -32'sh10000, 32'sh10000);
    add_write(2, -32'sh10000, -32'sh30000);
    add_write(3, Q_MAX, Q_MIN);
    set_points(1);
    add_lookup(5);
    set_points(2);
    add_lookup(Q_MIN);
    add_lookup(Q_MAX);
    add_lookup(0);
    add_lookup(-32'sh10000);
    add_lookup(-32'sh10001);
    add_lookup(Q_MIN + 1);
    // too few points repeats the last good y
    set_points(1);
    add_lookup($urandom);
    set_points(4);
    add_lookup(-32'sh10000);
    add_lookup(0);
    add_lookup(Q_MAX);
    add_lookup(-100000);
    // break the ordering
    add_write(1, 32'sh40000000, 32'sh7FFF0000);
    add_write(63, Q_MAX, Q_MIN);
    add_lookup(0);
    add_lookup(-1000000);

    // full table before any lookup can reach entries past the first few
    set_points(tli_pkg::MAX_POINTS);
    load_table(tli_pkg::MAX_POINTS, 0);
    for (int i = 0; i < 40; i++) add_lookup(pick_query(tli_pkg::MAX_POINTS));

    // receiver holds off while the sender keeps offering lookups
    set_points(tli_pkg::MAX_POINTS);
    idle_mode = 1'b0;
    hold_asked++;
    for (int i = 0; i < 40; i++) add_lookup(pick_query(tli_pkg::MAX_POINTS));

    while (n_pushed < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0: n = 0;
        1: n = 1;
        2: n = 2;
        3: n = tli_pkg::MAX_POINTS;
        4, 5: n = $urandom_range(3, 8);
        default: n = $urandom_range(2, tli_pkg::MAX_POINTS);
      endcase
      set_points(n);
      idle_mode = ($urandom_range(0, 9) < 7);
      if (n >= 2 && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: style = 1;
          1: style = 2;
          2: style = 3;
          default: style = 0;
        endcase
        load_table(n, style);
      end
      count = $urandom_range(15, 50);
      for (int i = 0; i < count; i++) begin
        case ($urandom_range(0, 49))
          0: add_write($urandom_range(0, tli_pkg::MAX_POINTS - 1), $urandom, $urandom);
          1: begin
            style = $urandom_range(0, tli_pkg::MAX_POINTS - 1);
            add_write(style, sx[style], $urandom);
          end
          default: add_lookup(pick_query(n));
        endcase
      end
    end

    settle();
    $display("covered %0d items: %0d table writes and %0d lookups, %0d results checked",
             n_accepted, n_writes, n_lookups, n_results);
    $display("lookups: %0d interpolated, %0d clamped at an end, %0d with too few points",
             n_interp, n_clamp, n_unusable);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/tli_pkg.sv
rtl/core/tli_if.sv
rtl/core/tli_table.sv
rtl/core/tli_muldiv.sv
rtl/core/table_linear_interpolator.sv
rtl/core/tli_checker.sv
test/table_linear_interpolator_tb.sv
